FILE: rtl/bbgb_pkg.sv
package bbgb_pkg;

  localparam int CW         = 32;  // coordinate width, signed Q16.16
  localparam int SCALE_W    = 32;  // unsigned Q16.16 scale
  localparam int FRAC_W     = 32;  // product bits dropped to reach a whole cell
  localparam int GRID_MAX   = 64;
  localparam int DIM_W      = 7;
  localparam int DIMS_W     = 3 * DIM_W;
  localparam int NXY_W      = 2 * DIM_W;
  localparam int ID_W       = 32;
  localparam int RAD_W      = 31;
  localparam int LO_W       = 6;
  localparam int HI_W       = 16;
  localparam int IDX_W      = 18;
  localparam int LO_MAX     = 63;
  localparam int HI_MIN     = -32768;
  localparam int FIFO_DEPTH = 4;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_SCALE_X   = 3'd3,
    REG_SCALE_Y   = 3'd4,
    REG_SCALE_Z   = 3'd5,
    REG_GRID_DIMS = 3'd6
  } reg_idx_e;

  // One box for the back end: bounds per axis, x in element 0.
  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [2:0][CW-1:0]    lo;
    logic [2:0][CW-1:0]    hi;
  } job_t;

  typedef struct packed {
    logic [2:0][CW-1:0]      origin;
    logic [2:0][SCALE_W-1:0] scale;
    logic [DIMS_W-1:0]       dims;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [2:0][LO_W-1:0]  lo;
    logic [2:0][HI_W-1:0]  hi;
    logic [IDX_W-1:0]      first_index;
    logic                  empty;
  } res_t;

  // A packed count of zero counts as one; counts above the grid limit saturate.
  function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] f);
    logic [DIM_W-1:0] n;
    n = f;
    if (n == '0) n = DIM_W'(1);
    if (n > DIM_W'(GRID_MAX)) n = DIM_W'(GRID_MAX);
    return n;
  endfunction

endpackage

FILE: rtl/bbgb_fifo.sv
module bbgb_fifo import bbgb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  job_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]   cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + PTR_W'(1) : wr_q;
    rd_d  = pop_i ? rd_q + PTR_W'(1) : rd_q;
    cnt_d = cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
  end

  assign full_o  = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/bbgb_front.sv
module bbgb_front import bbgb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic                sphere_i,
  input  logic                last_i,
  input  logic [ID_W-1:0]     id_i,
  input  logic [2:0][CW-1:0]  coord_i,
  input  logic [RAD_W-1:0]    radius_i,
  input  logic                full_i,
  output logic                push_o,
  output job_t                job_o
);

  logic               have_q, have_d;
  logic [2:0][CW-1:0] min_q, min_d, max_q, max_d;
  logic               acc;
  logic [CW:0]        rad_ext;
  logic [2:0][CW:0]   sum_lo, sum_hi;
  logic [2:0][CW-1:0] sat_lo, sat_hi;

  localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  always_comb begin
    acc     = valid_i & ~full_i;
    rad_ext = (CW+1)'(radius_i);
    have_d  = have_q;
    for (int a = 0; a < 3; a++) begin
      // The first vertex of a box sets both bounds.
      min_d[a] = (!have_q || $signed(coord_i[a]) < $signed(min_q[a])) ? coord_i[a] : min_q[a];
      max_d[a] = (!have_q || $signed(coord_i[a]) > $signed(max_q[a])) ? coord_i[a] : max_q[a];
      sum_lo[a] = {coord_i[a][CW-1], coord_i[a]} - rad_ext;
      sum_hi[a] = {coord_i[a][CW-1], coord_i[a]} + rad_ext;
      // A carry out that differs from the sign bit means the bound left the range.
      if (sum_lo[a][CW] != sum_lo[a][CW-1]) begin
        sat_lo[a] = sum_lo[a][CW] ? C_MIN : C_MAX;
      end else begin
        sat_lo[a] = sum_lo[a][CW-1:0];
      end
      if (sum_hi[a][CW] != sum_hi[a][CW-1]) begin
        sat_hi[a] = sum_hi[a][CW] ? C_MIN : C_MAX;
      end else begin
        sat_hi[a] = sum_hi[a][CW-1:0];
      end
    end
    if (acc && !sphere_i) begin
      have_d = ~last_i;
    end
    job_o.id = id_i;
    job_o.lo = sphere_i ? sat_lo : min_d;
    job_o.hi = sphere_i ? sat_hi : max_d;
    push_o   = acc & (sphere_i | last_i);
  end

  assign ready_o = ~full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && !sphere_i) begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

endmodule

FILE: rtl/bbgb_back.sv
module bbgb_back import bbgb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic valid_i,
  input  job_t job_i,
  output logic pop_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  localparam int IDXC_W = IDX_W + 2;

  logic adv;

  logic                 v1_q, v2_q, v3_q, v4_q, vo_q;
  logic [ID_W-1:0]      id1_q, id2_q, id3_q, id4_q;
  logic [2:0][CW:0]     dl1_d, dh1_d, dl1_q, dh1_q;
  logic [2:0]           nl2_q, nh2_q, nl3_q, nh3_q;
  logic [2:0][CW-1:0]   ml2_d, mh2_d, ml2_q, mh2_q;
  logic [2:0][CW+FRAC_W-1:0] pl, ph;
  logic [2:0][CW-1:0]   ql3_d, qh3_d, ql3_q, qh3_q;
  logic [2:0][LO_W-1:0] lo4_d, lo4_q;
  logic [2:0][HI_W-1:0] hi4_d, hi4_q;
  logic                 emp4_d, emp4_q;
  logic [NXY_W-1:0]     nxy_d, nxy_q;
  logic [IDXC_W-1:0]    idx_c;
  logic [DIM_W-1:0]     nx;
  res_t                 res_d, res_q;

  logic signed [CW:0]   cl, ch, al, bh, nm1;

  // Whole pipeline moves together; it halts only while a result waits.
  assign adv   = ~vo_q | ready_i;
  assign pop_o = adv & valid_i;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dl1_d[a] = {job_i.lo[a][CW-1], job_i.lo[a]} - {cfg_i.origin[a][CW-1], cfg_i.origin[a]};
      dh1_d[a] = {job_i.hi[a][CW-1], job_i.hi[a]} - {cfg_i.origin[a][CW-1], cfg_i.origin[a]};
      ml2_d[a] = dl1_q[a][CW] ? CW'(-dl1_q[a]) : dl1_q[a][CW-1:0];
      mh2_d[a] = dh1_q[a][CW] ? CW'(-dh1_q[a]) : dh1_q[a][CW-1:0];
      pl[a]    = (CW+FRAC_W)'(ml2_q[a]) * (CW+FRAC_W)'(cfg_i.scale[a]);
      ph[a]    = (CW+FRAC_W)'(mh2_q[a]) * (CW+FRAC_W)'(cfg_i.scale[a]);
      ql3_d[a] = pl[a][CW+FRAC_W-1:FRAC_W];
      qh3_d[a] = ph[a][CW+FRAC_W-1:FRAC_W];
    end
  end

  // Sign restore, clamping to the grid and the empty test.
  always_comb begin
    emp4_d = 1'b0;
    for (int a = 0; a < 3; a++) begin
      cl  = nl3_q[a] ? -$signed({1'b0, ql3_q[a]}) : $signed({1'b0, ql3_q[a]});
      ch  = nh3_q[a] ? -$signed({1'b0, qh3_q[a]}) : $signed({1'b0, qh3_q[a]});
      nm1 = $signed({{(CW+1-DIM_W){1'b0}},
                     dim_of(cfg_i.dims[a*DIM_W +: DIM_W]) - DIM_W'(1)});
      al  = (cl < 0) ? '0 : cl;
      bh  = (ch > nm1) ? nm1 : ch;
      if (al > bh) emp4_d = 1'b1;
      lo4_d[a] = (al > (CW+1)'(LO_MAX)) ? LO_W'(LO_MAX) : al[LO_W-1:0];
      hi4_d[a] = (bh < (CW+1)'(HI_MIN)) ? HI_W'(HI_MIN) : bh[HI_W-1:0];
    end
  end

  always_comb begin
    nx    = dim_of(cfg_i.dims[DIM_W-1:0]);
    nxy_d = NXY_W'(nx) * NXY_W'(dim_of(cfg_i.dims[DIM_W +: DIM_W]));
    idx_c = IDXC_W'(lo4_q[0]) + IDXC_W'(lo4_q[1]) * IDXC_W'(nx)
          + IDXC_W'(lo4_q[2]) * IDXC_W'(nxy_q);
    res_d.id          = id4_q;
    res_d.lo          = lo4_q;
    res_d.hi          = hi4_q;
    res_d.first_index = emp4_q ? '0 : idx_c[IDX_W-1:0];
    res_d.empty       = emp4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vo_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nxy_q <= nxy_d;
    if (adv) begin
      id1_q  <= job_i.id;
      dl1_q  <= dl1_d;
      dh1_q  <= dh1_d;
      id2_q  <= id1_q;
      for (int a = 0; a < 3; a++) begin
        nl2_q[a] <= dl1_q[a][CW];
        nh2_q[a] <= dh1_q[a][CW];
      end
      ml2_q  <= ml2_d;
      mh2_q  <= mh2_d;
      id3_q  <= id2_q;
      nl3_q  <= nl2_q;
      nh3_q  <= nh2_q;
      ql3_q  <= ql3_d;
      qh3_q  <= qh3_d;
      id4_q  <= id3_q;
      lo4_q  <= lo4_d;
      hi4_q  <= hi4_d;
      emp4_q <= emp4_d;
      res_q  <= res_d;
    end
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;

endmodule

FILE: rtl/bounding_box_grid_binning.sv
// Channel   Direction  Handshake                     Beat contents
// s_axis    in         s_axis_tvalid/s_axis_tready   vertex or sphere; tuser is_sphere, tlast last
// m_axis    out        m_axis_tvalid/m_axis_tready   cell ranges, first index; tuser empty_res
// apb       in         psel/penable, pready high     grid origin, scale and dimensions
//
// The input side takes one beat per cycle while the four-entry box queue has room.
// A box or sphere result waits in the box queue after its closing beat is taken and then passes
// through the back end, a five-stage pipeline whose third stage holds the six 32x32 scaling
// multipliers. A stalled output halts the back end only; the front keeps taking beats
// until the queue fills. Reset clears the pending box, the queue and all valid flags.
module bounding_box_grid_binning import bbgb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // object_id[31:0], coord_x[63:32], coord_y[95:64], coord_z[127:96],
  // radius[158:128], zero pad[159]
  input  logic [159:0]       s_axis_tdata,
  input  logic               s_axis_tlast,
  // is_sphere
  input  logic               s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // object_id_out[31:0], x_lo[37:32], x_hi[53:38], y_lo[59:54], y_hi[75:60],
  // z_lo[81:76], z_hi[97:82], first_index[115:98], zero pad[119:116]
  output logic [119:0]       m_axis_tdata,
  // empty_res
  output logic               m_axis_tuser,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  cfg_t               cfg_q;
  logic               cfg_wr;
  logic [2:0]         reg_sel;
  logic [2:0][CW-1:0] coord;

  logic               fifo_push, fifo_full, fifo_pop, fifo_empty;
  job_t               job_in, job_out;
  res_t               res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin <= '0;
      cfg_q.scale  <= {3{SCALE_W'(32'h0001_0000)}};
      cfg_q.dims   <= DIMS_W'(16513);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ORIGIN_X:  cfg_q.origin[0] <= pwdata[CW-1:0];
        REG_ORIGIN_Y:  cfg_q.origin[1] <= pwdata[CW-1:0];
        REG_ORIGIN_Z:  cfg_q.origin[2] <= pwdata[CW-1:0];
        REG_SCALE_X:   cfg_q.scale[0]  <= pwdata[SCALE_W-1:0];
        REG_SCALE_Y:   cfg_q.scale[1]  <= pwdata[SCALE_W-1:0];
        REG_SCALE_Z:   cfg_q.scale[2]  <= pwdata[SCALE_W-1:0];
        REG_GRID_DIMS: cfg_q.dims      <= pwdata[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ORIGIN_X:  prdata = cfg_q.origin[0];
      REG_ORIGIN_Y:  prdata = cfg_q.origin[1];
      REG_ORIGIN_Z:  prdata = cfg_q.origin[2];
      REG_SCALE_X:   prdata = cfg_q.scale[0];
      REG_SCALE_Y:   prdata = cfg_q.scale[1];
      REG_SCALE_Z:   prdata = cfg_q.scale[2];
      REG_GRID_DIMS: prdata = DATA_W'(cfg_q.dims);
      default:       prdata = '0;
    endcase
  end

  assign coord[0] = s_axis_tdata[63:32];
  assign coord[1] = s_axis_tdata[95:64];
  assign coord[2] = s_axis_tdata[127:96];

  bbgb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .sphere_i (s_axis_tuser),
    .last_i   (s_axis_tlast),
    .id_i     (s_axis_tdata[31:0]),
    .coord_i  (coord),
    .radius_i (s_axis_tdata[158:128]),
    .full_i   (fifo_full),
    .push_o   (fifo_push),
    .job_o    (job_in)
  );

  bbgb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (job_in),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .data_o  (job_out),
    .empty_o (fifo_empty)
  );

  bbgb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (~fifo_empty),
    .job_i   (job_out),
    .pop_o   (fifo_pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = {4'b0, res.first_index, res.hi[2], res.lo[2], res.hi[1], res.lo[1],
                         res.hi[0], res.lo[0], res.id};
  assign m_axis_tuser = res.empty;

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_full)
    else $error("box queue written while full");

  a_sphere_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !fifo_empty)
    else $error("accepted sphere did not reach the box queue");

  a_empty_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.empty) |-> (res.first_index == '0))
    else $error("empty result carries a cell index");

  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res.empty) |->
      ($signed({10'b0, res.lo[0]}) <= $signed(res.hi[0]) &&
       $signed({10'b0, res.lo[1]}) <= $signed(res.hi[1]) &&
       $signed({10'b0, res.lo[2]}) <= $signed(res.hi[2])))
    else $error("non-empty result with an inverted cell range");
`endif

endmodule

FILE: verif/tb_bounding_box_grid_binning.sv
module tb_bounding_box_grid_binning;
  import bbgb_pkg::*;

  localparam int          BATCH_BEATS = 48;
  localparam int          DRAIN_WAIT  = 12;
  localparam int          HOLD_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          BAD_REG_IDX = int'(REG_GRID_DIMS) + 1;

  typedef struct packed {
    logic        sph;
    logic [31:0] id;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [30:0] rad;
    logic        last;
  } beat_t;

  typedef struct packed {
    logic [31:0]           id;
    logic [2:0][LO_W-1:0]  lo;
    logic [2:0][HI_W-1:0]  hi;
    logic [IDX_W-1:0]      idx;
    logic                  empty;
  } bins_t;

  class bin_scoreboard;
    longint          org[3];
    longint unsigned scl[3];
    logic [20:0]     dims;
    longint          box_min[3];
    longint          box_max[3];
    bit              box_open;
    bins_t           bins_due[$];
    int              errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        org[i]     = 0;
        scl[i]     = 65536;
        box_min[i] = 0;
        box_max[i] = 0;
      end
      dims     = 21'd16513;
      box_open = 0;
      errors   = 0;
    endfunction

    function void write_reg(int idx, logic [31:0] v);
      if (idx <= int'(REG_ORIGIN_Z)) begin
        org[idx] = $signed(v);
      end else if (idx <= int'(REG_SCALE_Z)) begin
        scl[idx - int'(REG_SCALE_X)] = v;
      end else if (idx == int'(REG_GRID_DIMS)) begin
        dims = v[20:0];
      end
    endfunction

    function int pending();
      return bins_due.size();
    endfunction

    function longint clamp_coord(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Whole cells from (bound - origin) * scale, truncated toward zero.
    function longint cell_of(longint bound, longint o, longint unsigned s);
      longint          d;
      longint unsigned mag, mh, ml, q;
      d   = bound - o;
      mag = (d < 0) ? -d : d;
      mh  = mag >> 32;
      ml  = mag & 64'hFFFF_FFFF;
      q   = mh * s + ((ml * s) >> 32);
      if (q > (64'd1 << 50)) q = 64'd1 << 50;
      return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint axis_cells(int sh);
      longint n;
      n = dims[sh +: 7];
      if (n < 1) n = 1;
      if (n > GRID_MAX) n = GRID_MAX;
      return n;
    endfunction

    function void note_beat(beat_t b);
      longint c[3], lo_b[3], hi_b[3], lc[3], nn[3];
      longint r, a, z;
      bins_t  e;
      c[0] = $signed(b.cx);
      c[1] = $signed(b.cy);
      c[2] = $signed(b.cz);
      r    = b.rad;
      for (int i = 0; i < 3; i++) nn[i] = axis_cells(7 * i);
      if (b.sph) begin
        for (int i = 0; i < 3; i++) begin
          lo_b[i] = clamp_coord(c[i] - r);
          hi_b[i] = clamp_coord(c[i] + r);
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (!box_open || c[i] < box_min[i]) box_min[i] = c[i];
          if (!box_open || c[i] > box_max[i]) box_max[i] = c[i];
        end
        box_open = 1;
        if (!b.last) return;
        box_open = 0;
        lo_b = box_min;
        hi_b = box_max;
      end
      e.id    = b.id;
      e.empty = 1'b0;
      for (int i = 0; i < 3; i++) begin
        a = cell_of(lo_b[i], org[i], scl[i]);
        z = cell_of(hi_b[i], org[i], scl[i]);
        if (a < 0) a = 0;
        if (z > nn[i] - 1) z = nn[i] - 1;
        if (a > z) e.empty = 1'b1;
        lc[i]   = a;
        e.lo[i] = LO_W'((a > LO_MAX) ? LO_MAX : a);
        e.hi[i] = HI_W'((z < HI_MIN) ? HI_MIN : z);
      end
      e.idx = e.empty ? '0 : IDX_W'(lc[0] + lc[1] * nn[0] + lc[2] * nn[0] * nn[1]);
      bins_due.push_back(e);
    endfunction

    function void report(string what, longint unsigned want, longint unsigned got);
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    endfunction

    function void check_bins(logic [119:0] d, logic u);
      bins_t got, want;
      got.id    = d[31:0];
      got.lo[0] = d[37:32];
      got.hi[0] = d[53:38];
      got.lo[1] = d[59:54];
      got.hi[1] = d[75:60];
      got.lo[2] = d[81:76];
      got.hi[2] = d[97:82];
      got.idx   = d[115:98];
      got.empty = u;
      if (bins_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none got id %0h", $time, got.id);
        return;
      end
      want = bins_due.pop_front();
      if (got.id != want.id) report("object_id_out", want.id, got.id);
      for (int i = 0; i < 3; i++) begin
        if (got.lo[i] != want.lo[i]) report($sformatf("lo[%0d]", i), want.lo[i], got.lo[i]);
        if (got.hi[i] != want.hi[i]) report($sformatf("hi[%0d]", i), want.hi[i], got.hi[i]);
      end
      if (got.idx != want.idx) report("first_index", want.idx, got.idx);
      if (got.empty != want.empty) report("empty_res", want.empty, got.empty);
    endfunction
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [159:0]       s_axis_tdata  = '0;
  logic               s_axis_tlast  = 1'b0;
  logic               s_axis_tuser  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [119:0]       m_axis_tdata;
  logic               m_axis_tuser;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [ADDR_W-1:0]  paddr         = '0;
  logic [DATA_W-1:0]  pwdata        = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  bin_scoreboard sb = new();
  int            src_idle  = 6;
  int            snk_idle  = 87;
  bit            hold_req  = 0;
  int            hold_left = 0;
  int unsigned   cycles    = 0;

  bounding_box_grid_binning i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_bins(m_axis_tdata, m_axis_tuser);
  end

  // Result side: random back-pressure, or a long hold-off once asked for.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  function automatic logic [31:0] dims_word(int nx, int ny, int nz);
    return 32'(nx | (ny << 7) | (nz << 14));
  endfunction

  function automatic logic [31:0] pick_coord(longint cen, longint span);
    int m;
    m = $urandom_range(99);
    if (m < 75) return 32'(cen - span + longint'($urandom_range(32'(2 * span))));
    if (m < 92) return $urandom;
    case ($urandom_range(3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic beat_t rand_beat(longint cen, longint span, logic sph, logic last);
    beat_t b;
    b.sph  = sph;
    b.id   = $urandom;
    b.cx   = pick_coord(cen, span);
    b.cy   = pick_coord(cen, span);
    b.cz   = pick_coord(cen, span);
    b.rad  = ($urandom_range(2) == 0) ? 31'($urandom) : 31'($urandom_range(32'(span)));
    b.last = last;
    return b;
  endfunction

  function automatic beat_t mk(logic sph, logic [31:0] id, logic [31:0] x, logic [31:0] y,
                               logic [31:0] z, logic [30:0] r, logic last);
    beat_t b;
    b.sph  = sph;
    b.id   = id;
    b.cx   = x;
    b.cy   = y;
    b.cz   = z;
    b.rad  = r;
    b.last = last;
    return b;
  endfunction

  // Called just after a falling edge; returns just after a falling edge.
  task automatic push_beat(beat_t b);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, b.rad, b.cz, b.cy, b.cx, b.id};
    s_axis_tlast  <= b.last;
    s_axis_tuser  <= b.sph;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(b);
    @(negedge clk_i);
  endtask

  task automatic apb_write(int idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_batch(int b);
    logic [31:0] rv[7];
    longint      cen, span;
    int          sent, k, nv, j;
    bit          paused;
    cen  = 0;
    span = 64'sd1 << 30;
    case (b)
      0: begin
        for (j = 0; j < 3; j++) rv[j] = 32'h0;
        for (j = 3; j < 6; j++) rv[j] = 32'h0001_0000;
        rv[REG_GRID_DIMS] = dims_word(8, 8, 8);
        cen  = 64'sd4 << 16;
        span = 64'sd8 << 16;
      end
      1: begin
        for (j = 0; j < 3; j++) rv[j] = 32'hFFFC_0000;
        for (j = 3; j < 6; j++) rv[j] = 32'h0002_0000;
        rv[REG_GRID_DIMS] = dims_word(16, 4, 64);
        span = 64'sd20 << 16;
      end
      2: begin
        rv[REG_ORIGIN_X] = 32'h8000_0000;
        rv[REG_ORIGIN_Y] = 32'h7FFF_FFFF;
        rv[REG_ORIGIN_Z] = 32'h0;
        for (j = 3; j < 6; j++) rv[j] = 32'hFFFF_FFFF;
        rv[REG_GRID_DIMS] = 32'h0;
        span = 64'sd1 << 16;
      end
      3: begin
        for (j = 0; j < 3; j++) rv[j] = $urandom;
        for (j = 3; j < 6; j++) rv[j] = 32'h0;
        rv[REG_GRID_DIMS] = dims_word(127, 127, 127);
      end
      4: begin
        for (j = 0; j < 3; j++) rv[j] = 32'($urandom_range(32'h0010_0000)) - 32'h0008_0000;
        for (j = 3; j < 6; j++) rv[j] = $urandom_range(32'h0004_0000, 32'h0000_4000);
        rv[REG_GRID_DIMS] = dims_word($urandom_range(64, 1), $urandom_range(64, 1),
                                      $urandom_range(64, 1));
        span = 64'sd32 << 16;
      end
      5: begin
        for (j = 0; j < 3; j++) rv[j] = 32'h0;
        for (j = 3; j < 6; j++) rv[j] = 32'h0000_0100;
        rv[REG_GRID_DIMS] = dims_word(64, 64, 64);
      end
      6: begin
        for (j = 0; j < 6; j++) rv[j] = $urandom;
        rv[REG_GRID_DIMS] = $urandom;
      end
      default: begin
        for (j = 0; j < 3; j++) rv[j] = 32'h0;
        for (j = 3; j < 6; j++) rv[j] = 32'h0001_0000;
        rv[REG_GRID_DIMS] = 32'd16513;
        span = 64'sd2 << 16;
      end
    endcase
    if (b < 3) begin
      src_idle = 6;
      snk_idle = 87;
    end else if (b < 6) begin
      src_idle = 87;
      snk_idle = 6;
    end else begin
      src_idle = 0;
      snk_idle = 0;
    end
    for (j = int'(REG_ORIGIN_X); j <= int'(REG_GRID_DIMS); j++) apb_write(j, rv[j]);
    // An address past the last register must leave the grid untouched.
    if (b == 0) apb_write(BAD_REG_IDX, $urandom);
    if (b == 6) hold_req = 1;
    sent   = 0;
    paused = 0;
    while (sent < BATCH_BEATS) begin
      if (b == 6 && !paused && sent >= BATCH_BEATS / 2) begin
        paused = 1;
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
      k = $urandom_range(99);
      if (k < 35) begin
        push_beat(rand_beat(cen, span, 1'b1, 1'($urandom)));
        sent++;
      end else if (k < 92) begin
        nv = $urandom_range(1) ? 4 : $urandom_range(6, 1);
        for (j = 0; j < nv; j++) begin
          push_beat(rand_beat(cen, span, 1'b0, j == nv - 1));
          sent++;
        end
      end else begin
        // A stray vertex beat that folds into whatever box comes next.
        push_beat(rand_beat(cen, span, 1'b0, 1'b0));
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
    drain();
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed beats under the reset grid: one cell, origin zero, unit scale.
    push_beat(mk(1, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0, 0));
    push_beat(mk(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 31'h7FFF_FFFF, 1));
    push_beat(mk(1, 32'h1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 1));
    push_beat(mk(0, 32'h2, 32'h8000, 32'h8000, 32'h8000, 31'h0, 1));
    push_beat(mk(0, 32'h3, 32'h0, 32'h0, 32'h0, 31'h1234, 0));
    push_beat(mk(0, 32'h4, 32'h1_0000, 32'hFFFF_0000, 32'h4000, 31'h0, 0));
    push_beat(mk(0, 32'h5, 32'hFFFE_0000, 32'h3_0000, 32'h0, 31'h0, 0));
    push_beat(mk(0, 32'h6, 32'h7FFF, 32'h0, 32'hFFFF_8000, 31'h0, 1));
    push_beat(mk(0, 32'h7, 32'h2_0000, 32'h1_0000, 32'hFFFF_0000, 31'h0, 0));
    push_beat(mk(1, 32'h8, 32'h0, 32'h0, 32'h0, 31'h8000, 0));
    push_beat(mk(0, 32'h9, 32'hFFFF_0000, 32'h0, 32'h1_0000, 31'h0, 1));
    push_beat(mk(0, 32'hA, 32'h64_0000, 32'h64_0000, 32'h64_0000, 31'h0, 1));
    push_beat(mk(0, 32'hB, 32'hFF9C_0000, 32'hFF9C_0000, 32'hFF9C_0000, 31'h0, 1));
    push_beat(mk(0, 32'hC, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0, 1));
    push_beat(mk(0, 32'hD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1));
    s_axis_tvalid <= 1'b0;
    drain();

    for (int b = 0; b < 8; b++) run_batch(b);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bbgb_pkg.sv
rtl/bbgb_fifo.sv
rtl/bbgb_front.sv
rtl/bbgb_back.sv
rtl/bounding_box_grid_binning.sv
verif/tb_bounding_box_grid_binning.sv
